>>> src/fpr_pkg.sv
// fpr_pkg: widths, register indexes and controller/datapath interface types
// for the flow pulse rate meter; used by every module of the block
`default_nettype none

package fpr_pkg;

	localparam int WINDOW_BITS   = 24;
	localparam int FRACTION_BITS = 16;

	localparam int CFG_W     = 16;
	localparam int ELAPSED_W = 32;
	localparam int TOTAL_W   = 32;
	localparam int RATE_W    = 32;
	localparam int MIN_W     = 38;
	localparam int HOUR_W    = 44;
	localparam int VOL_W     = 48;

	// signed sum of pulses per liter and calibration, and its positive range
	localparam int SDIV_W = CFG_W + 2;
	localparam int DSOR_W = CFG_W + 1;

	localparam int SCALE_W  = 10;
	localparam int NUM_W    = WINDOW_BITS + SCALE_W;
	localparam int DVD_W    = NUM_W + FRACTION_BITS;
	localparam int DEN_W    = DSOR_W + ELAPSED_W;
	localparam int CNT_W    = $clog2(DVD_W);
	localparam int QX_W     = ((DVD_W > RATE_W) ? DVD_W : RATE_W) + 1;
	localparam int SUM_W    = ((DVD_W > VOL_W) ? DVD_W : VOL_W) + 1;

	localparam logic [NUM_W-1:0]  MS_PER_S   = NUM_W'(1000);
	localparam logic [MIN_W-1:0]  S_PER_MIN  = MIN_W'(60);
	localparam logic [HOUR_W-1:0] S_PER_HOUR = HOUR_W'(3600);

	// configuration register indexes
	localparam logic REG_PULSES_PER_LITER = 1'b0;
	localparam logic REG_CALIBRATION      = 1'b1;

	typedef struct packed {
		logic load;
		logic eval;
		logic step;
		logic update;
		logic finish;
	} fpr_cmd_t;

	typedef struct packed {
		logic sample;
		logic div_err;
		logic elapsed_zero;
	} fpr_stat_t;

endpackage

`default_nettype wire

>>> src/fpr_ctrl.sv
// fpr_ctrl: sequencing state machine of the flow pulse rate meter
// depends on fpr_pkg for the command and status types
`default_nettype none

module fpr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire fpr_pkg::fpr_stat_t stat,
	output fpr_pkg::fpr_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]                  state_q;
	logic [2:0]                  state_d;
	logic [fpr_pkg::CNT_W-1:0]   cnt_q;
	logic                        out_valid_q;
	logic                        start;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign start     = stat.sample & ~stat.div_err & ~stat.elapsed_zero;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = start ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.eval) begin
				cnt_q <= fpr_pkg::CNT_W'(fpr_pkg::DVD_W - 1);
			end else if (cmd.step) begin
				cnt_q <= cnt_q - fpr_pkg::CNT_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/fpr_dp.sv
// fpr_dp: counters, configuration, two-lane restoring divider and output
// register of the flow pulse rate meter; depends on fpr_pkg
`default_nettype none

module fpr_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic                          cfg_addr,
	input  wire logic [fpr_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                          pulse,
	input  wire logic                          tick_ms,
	input  wire logic                          sample,
	input  wire logic                          clear_pulses,
	input  wire logic                          clear_volume,
	input  wire fpr_pkg::fpr_cmd_t             cmd,
	output fpr_pkg::fpr_stat_t                 stat,
	output logic [fpr_pkg::RATE_W-1:0]         rate_per_second,
	output logic [fpr_pkg::MIN_W-1:0]          rate_per_minute,
	output logic [fpr_pkg::HOUR_W-1:0]         rate_per_hour,
	output logic [fpr_pkg::VOL_W-1:0]          volume_liters,
	output logic [fpr_pkg::TOTAL_W-1:0]        pulse_total,
	output logic                               updated,
	output logic                               divisor_error
);

	localparam int WB  = fpr_pkg::WINDOW_BITS;
	localparam int FB  = fpr_pkg::FRACTION_BITS;
	localparam int DVW = fpr_pkg::DVD_W;
	localparam int DNW = fpr_pkg::DEN_W;

	logic [fpr_pkg::CFG_W-1:0]     ppl_q;
	logic [fpr_pkg::CFG_W-1:0]     cal_q;
	logic [WB-1:0]                 window_q;
	logic [fpr_pkg::ELAPSED_W-1:0] elapsed_q;
	logic [fpr_pkg::TOTAL_W-1:0]   total_q;
	logic [fpr_pkg::RATE_W-1:0]    rate_q;
	logic [fpr_pkg::VOL_W-1:0]     vol_q;
	logic                          updated_q;
	logic                          sample_q;
	logic                          clrp_q;
	logic                          clrv_q;

	logic [DNW-1:0] den_rate_q;
	logic [DNW-1:0] den_vol_q;
	logic [DVW-1:0] dvd_rate_q;
	logic [DVW-1:0] dvd_vol_q;
	logic [DNW-1:0] rem_rate_q;
	logic [DNW-1:0] rem_vol_q;
	logic [DVW-1:0] quo_rate_q;
	logic [DVW-1:0] quo_vol_q;

	logic [fpr_pkg::SDIV_W-1:0] divisor;
	logic [fpr_pkg::DSOR_W-1:0] dsor;
	logic                       div_err;
	logic [fpr_pkg::NUM_W-1:0]  num;

	logic [DNW:0] r_rate, r_vol, diff_rate, diff_vol;
	logic         ge_rate, ge_vol;

	logic [fpr_pkg::QX_W-1:0]   qx;
	logic [fpr_pkg::RATE_W-1:0] rate_next;
	logic [fpr_pkg::SUM_W-1:0]  vol_sum;
	logic [fpr_pkg::VOL_W-1:0]  vol_next;

	assign divisor = {2'b00, ppl_q} + {{2{cal_q[fpr_pkg::CFG_W-1]}}, cal_q};
	assign div_err = divisor[fpr_pkg::SDIV_W-1] | (divisor == '0);
	assign dsor    = divisor[fpr_pkg::DSOR_W-1:0];
	assign num     = fpr_pkg::NUM_W'(window_q) * fpr_pkg::MS_PER_S;

	assign stat.sample       = sample_q;
	assign stat.div_err      = div_err;
	assign stat.elapsed_zero = (elapsed_q == '0);

	// one restoring step per lane
	assign r_rate    = {rem_rate_q, dvd_rate_q[DVW-1]};
	assign diff_rate = r_rate - {1'b0, den_rate_q};
	assign ge_rate   = (r_rate >= {1'b0, den_rate_q});
	assign r_vol     = {rem_vol_q, dvd_vol_q[DVW-1]};
	assign diff_vol  = r_vol - {1'b0, den_vol_q};
	assign ge_vol    = (r_vol >= {1'b0, den_vol_q});

	assign qx        = fpr_pkg::QX_W'(quo_rate_q);
	assign rate_next = (qx[fpr_pkg::QX_W-1:fpr_pkg::RATE_W] != '0) ? '1
	                                                               : qx[fpr_pkg::RATE_W-1:0];
	assign vol_sum   = fpr_pkg::SUM_W'(vol_q) + fpr_pkg::SUM_W'(quo_vol_q);
	assign vol_next  = (vol_sum[fpr_pkg::SUM_W-1:fpr_pkg::VOL_W] != '0) ? '1
	                                                                    : vol_sum[fpr_pkg::VOL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppl_q     <= fpr_pkg::CFG_W'(450);
			cal_q     <= '0;
			window_q  <= '0;
			elapsed_q <= '0;
			total_q   <= '0;
			rate_q    <= '0;
			vol_q     <= '0;
			updated_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					fpr_pkg::REG_PULSES_PER_LITER: ppl_q <= cfg_wdata;
					fpr_pkg::REG_CALIBRATION:      cal_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.load) begin
				updated_q <= 1'b0;
				if (pulse) begin
					window_q <= window_q + WB'(1);
				end
				if (tick_ms) begin
					elapsed_q <= elapsed_q + fpr_pkg::ELAPSED_W'(1);
				end
			end else if (cmd.update) begin
				rate_q    <= rate_next;
				vol_q     <= vol_next;
				total_q   <= total_q + fpr_pkg::TOTAL_W'(window_q);
				window_q  <= '0;
				elapsed_q <= '0;
				updated_q <= 1'b1;
			end else if (cmd.finish) begin
				if (clrp_q) begin
					window_q <= '0;
					total_q  <= '0;
				end
				if (clrv_q) begin
					vol_q <= '0;
				end
			end
		end
	end

	// item flags and divider
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
			clrp_q   <= clear_pulses;
			clrv_q   <= clear_volume;
		end
		if (cmd.eval) begin
			den_rate_q <= DNW'(dsor) * DNW'(elapsed_q);
			den_vol_q  <= DNW'(dsor);
			dvd_rate_q <= {num, {FB{1'b0}}};
			dvd_vol_q  <= DVW'({window_q, {FB{1'b0}}});
			rem_rate_q <= '0;
			rem_vol_q  <= '0;
			quo_rate_q <= '0;
			quo_vol_q  <= '0;
		end else if (cmd.step) begin
			rem_rate_q <= ge_rate ? diff_rate[DNW-1:0] : r_rate[DNW-1:0];
			rem_vol_q  <= ge_vol ? diff_vol[DNW-1:0] : r_vol[DNW-1:0];
			dvd_rate_q <= {dvd_rate_q[DVW-2:0], 1'b0};
			dvd_vol_q  <= {dvd_vol_q[DVW-2:0], 1'b0};
			quo_rate_q <= {quo_rate_q[DVW-2:0], ge_rate};
			quo_vol_q  <= {quo_vol_q[DVW-2:0], ge_vol};
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rate_per_second <= rate_q;
			rate_per_minute <= fpr_pkg::MIN_W'(rate_q) * fpr_pkg::S_PER_MIN;
			rate_per_hour   <= fpr_pkg::HOUR_W'(rate_q) * fpr_pkg::S_PER_HOUR;
			volume_liters   <= clrv_q ? '0 : vol_q;
			pulse_total     <= clrp_q ? '0 : total_q;
			updated         <= updated_q;
			divisor_error   <= sample_q & div_err;
		end
	end

endmodule

`default_nettype wire

>>> src/flow_pulse_rate_meter.sv
// flow_pulse_rate_meter: top level, joins fpr_ctrl and fpr_dp
// depends on fpr_pkg, fpr_ctrl and fpr_dp
`default_nettype none

// Pulse flow meter. Each input beat carries one pulse flag, one millisecond
// tick, a sample request and two clears; each produces one output beat with
// the flow rate per second, minute and hour, the volume and the pulse total.
// Beats are handled one at a time. A beat without a valid sample passes
// load, evaluation and finish; a sample that updates rate and volume also
// passes the bit-serial restoring divider, which produces one quotient bit
// per cycle for rate and volume side by side, then an update. A new beat is
// accepted while the previous result still waits on the output. The user
// must write configuration only while idle; the block does not enforce it.
module flow_pulse_rate_meter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic                          cfg_addr,
	input  wire logic [fpr_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          pulse,
	input  wire logic                          tick_ms,
	input  wire logic                          sample,
	input  wire logic                          clear_pulses,
	input  wire logic                          clear_volume,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [fpr_pkg::RATE_W-1:0]         rate_per_second,
	output logic [fpr_pkg::MIN_W-1:0]          rate_per_minute,
	output logic [fpr_pkg::HOUR_W-1:0]         rate_per_hour,
	output logic [fpr_pkg::VOL_W-1:0]          volume_liters,
	output logic [fpr_pkg::TOTAL_W-1:0]        pulse_total,
	output logic                               updated,
	output logic                               divisor_error
);

	fpr_pkg::fpr_cmd_t  cmd;
	fpr_pkg::fpr_stat_t stat;

	fpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fpr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.pulse           (pulse),
		.tick_ms         (tick_ms),
		.sample          (sample),
		.clear_pulses    (clear_pulses),
		.clear_volume    (clear_volume),
		.cmd             (cmd),
		.stat            (stat),
		.rate_per_second (rate_per_second),
		.rate_per_minute (rate_per_minute),
		.rate_per_hour   (rate_per_hour),
		.volume_liters   (volume_liters),
		.pulse_total     (pulse_total),
		.updated         (updated),
		.divisor_error   (divisor_error)
	);

endmodule

`default_nettype wire

>>> src/fpr_checker.sv
// fpr_checker: port-level assertions for flow_pulse_rate_meter, bound to it
// depends on fpr_pkg for port widths
`default_nettype none

module fpr_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [fpr_pkg::RATE_W-1:0]    rate_per_second,
	input wire logic [fpr_pkg::MIN_W-1:0]     rate_per_minute,
	input wire logic [fpr_pkg::HOUR_W-1:0]    rate_per_hour,
	input wire logic                          updated,
	input wire logic                          divisor_error
);

	// one beat in flight: no second accept right after one
	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a beat is in flight");

	// a result cannot both update and flag a bad divisor
	a_upd_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(updated && divisor_error))
		else $error("updated and divisor_error both set");

	// scaled rates follow the per second rate
	a_scaled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rate_per_minute == ({6'b0, rate_per_second} * 38'd60)) &&
		              (rate_per_hour == ({12'b0, rate_per_second} * 44'd3600)))
		else $error("scaled rates do not match rate_per_second");

	// stalled result holds: out_valid and rate_per_second stay
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(rate_per_second))
		else $error("stalled output beat changed");

endmodule

bind flow_pulse_rate_meter fpr_checker u_fpr_checker (.*);

`default_nettype wire
